FILE: design/anchored_template_matcher_assert.svh
// Assertion macros used by the matcher checker.
`ifndef ANCHORED_TEMPLATE_MATCHER_ASSERT_SVH
`define ANCHORED_TEMPLATE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATM_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("matcher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("matcher check failed");

`endif

FILE: design/atm_pkg.sv
// Shared constants and types of the anchored template matcher.
`timescale 1ns / 1ps
`default_nettype none
package atm_pkg;

  localparam int TEMPLATE_DEPTH = 64;
  localparam int MAX_GROUPS     = 8;
  localparam int POSITION_BITS  = 16;
  localparam int REPORT_LIMIT   = 8;

  localparam int ADDR_BITS  = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
  localparam int PTR_BITS   = $clog2(TEMPLATE_DEPTH + 1);
  localparam int GROUP_BITS = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GROUP_LIMIT = (MAX_GROUPS < REPORT_LIMIT) ? MAX_GROUPS : REPORT_LIMIT;

  localparam int KIND_BITS    = 3;
  localparam int OPERAND_BITS = 8;
  localparam int ENTRY_BITS   = KIND_BITS + OPERAND_BITS;
  localparam int LEN_BITS     = 7;
  localparam int CNT_BITS     = 4;
  localparam int CFG_BITS     = 7;
  localparam int GNUM_BITS    = 3;
  localparam int OUT_POS_BITS = 16;

  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 40;

  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [PTR_BITS-1:0]      ptr_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [GROUP_BITS-1:0]    gidx_t;
  typedef logic [KIND_BITS-1:0]     kind_t;
  typedef logic [OPERAND_BITS-1:0]  operand_t;
  typedef logic [OUT_POS_BITS-1:0]  out_pos_t;
  typedef logic [GNUM_BITS-1:0]     gnum_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_END   = 2'd3;

  localparam kind_t KIND_LITERAL = 3'd0;
  localparam kind_t KIND_ANY     = 3'd1;
  localparam kind_t KIND_DIGIT   = 3'd2;
  localparam kind_t KIND_END     = 3'd3;
  localparam kind_t KIND_OPEN    = 3'd4;
  localparam kind_t KIND_CLOSE   = 3'd5;

  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_CAPTURE_COUNT  = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FAIL = 2'd2;

  localparam operand_t DIGIT_LO = 8'h30;
  localparam operand_t DIGIT_HI = 8'h39;

endpackage
`default_nettype wire

FILE: design/atm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module atm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/anchored_template_matcher.sv
// Top level of the anchored template matcher.
`timescale 1ns / 1ps
`default_nettype none
// Anchored, non-backtracking matcher of a byte stream against a compiled template
// held in a 64-entry store. Load, start and ignored items are handled in the idle
// state. A source byte or an end of source that meets a live template is scanned
// one template entry at a time: each capture entry stepped through, each end entry
// passed at end of source, and the entry that tests the byte or fails. The template
// store has registered read data and is read once per entry visited. A verdict is
// then followed by its results (failure: one, success: max(1, capture groups capped
// at eight)), each loaded as the output register frees. A new item is taken while
// the last result still waits.
module anchored_template_matcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // entry_slot[5:0], entry_kind[8:6], entry_operand[16:9], source_byte[24:17], zero
  input  wire logic [31:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // group_number[2:0], group_begin[18:3], group_end[34:19], group_valid[35], zero
  output logic [39:0]      out_tdata,
  // matched
  output logic             out_tuser,
  output logic             out_tlast
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  localparam logic [1:0] REP_FAIL   = 2'd0;
  localparam logic [1:0] REP_NONE   = 2'd1;
  localparam logic [1:0] REP_GROUPS = 2'd2;

  logic [atm_pkg::LEN_BITS-1:0] pat_len_r;
  atm_pkg::cnt_t                cap_cnt_r;

  logic [1:0]      state_r, state_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic            mode_end_r, mode_end_nxt;
  atm_pkg::ptr_t   ptr_r, ptr_nxt;
  atm_pkg::pos_t   pos_r, pos_nxt;
  atm_pkg::operand_t byte_r, byte_nxt;
  logic [1:0]      rep_mode_r, rep_mode_nxt;
  atm_pkg::gidx_t  rep_k_r, rep_k_nxt;

  logic [atm_pkg::MAX_GROUPS-1:0] beg_vld_r, beg_vld_nxt;
  logic [atm_pkg::MAX_GROUPS-1:0] end_vld_r, end_vld_nxt;
  atm_pkg::pos_t  beg_pos_r [atm_pkg::MAX_GROUPS];
  atm_pkg::pos_t  end_pos_r [atm_pkg::MAX_GROUPS];
  logic           rec_we;
  logic           rec_open;
  atm_pkg::gidx_t rec_idx;

  logic                           out_vld_r, out_vld_nxt;
  logic                           out_load;
  logic [atm_pkg::OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic                           out_match_r, out_match_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [atm_pkg::ENTRY_BITS-1:0] rd_data;
  atm_pkg::addr_t                 rd_addr;
  logic                           ld_we;

  logic              in_xfer;
  logic [1:0]        act;
  logic [5:0]        in_slot;
  atm_pkg::kind_t    in_kind;
  atm_pkg::operand_t in_opnd;
  atm_pkg::operand_t in_byte;

  atm_pkg::ptr_t     used_len;
  atm_pkg::ptr_t     ptr_inc;
  atm_pkg::pos_t     pos_adv;
  atm_pkg::kind_t    e_kind;
  atm_pkg::operand_t e_opnd;
  logic              e_cap;
  logic              byte_ok;
  atm_pkg::cnt_t     rep_n;
  logic              rep_last;
  atm_pkg::pos_t     rep_beg;
  atm_pkg::pos_t     rep_end;
  logic              out_free;

  assign act     = in_tuser;
  assign in_slot = in_tdata[5:0];
  assign in_kind = in_tdata[8:6];
  assign in_opnd = in_tdata[16:9];
  assign in_byte = in_tdata[24:17];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign used_len = (32'(pat_len_r) > atm_pkg::TEMPLATE_DEPTH) ?
                    atm_pkg::ptr_t'(atm_pkg::TEMPLATE_DEPTH) :
                    atm_pkg::ptr_t'(pat_len_r);
  assign ptr_inc  = ptr_r + atm_pkg::ptr_t'(1);
  assign pos_adv  = (pos_r != '1) ? pos_r + atm_pkg::pos_t'(1) : pos_r;

  assign ld_we   = in_xfer && (act == atm_pkg::ACT_LOAD) &&
                   (32'(in_slot) < atm_pkg::TEMPLATE_DEPTH);
  assign rd_addr = atm_pkg::addr_t'((state_r == ST_SCAN) ? ptr_inc : ptr_r);

  atm_ram #(
    .WIDTH (atm_pkg::ENTRY_BITS),
    .DEPTH (atm_pkg::TEMPLATE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ld_we),
    .waddr (atm_pkg::addr_t'(in_slot)),
    .wdata ({in_kind, in_opnd}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign e_kind  = rd_data[atm_pkg::ENTRY_BITS-1:atm_pkg::OPERAND_BITS];
  assign e_opnd  = rd_data[atm_pkg::OPERAND_BITS-1:0];
  assign e_cap   = (e_kind == atm_pkg::KIND_OPEN) || (e_kind == atm_pkg::KIND_CLOSE);

  always_comb begin
    byte_ok = 1'b0;
    unique case (e_kind)
      atm_pkg::KIND_LITERAL: byte_ok = (byte_r == e_opnd);
      atm_pkg::KIND_ANY:     byte_ok = 1'b1;
      atm_pkg::KIND_DIGIT:   byte_ok = (byte_r >= atm_pkg::DIGIT_LO) &&
                                       (byte_r <= atm_pkg::DIGIT_HI);
      default:               byte_ok = 1'b0;
    endcase
  end

  assign rep_n    = (32'(cap_cnt_r) > atm_pkg::GROUP_LIMIT) ?
                    atm_pkg::cnt_t'(atm_pkg::GROUP_LIMIT) : cap_cnt_r;
  assign rep_last = (atm_pkg::cnt_t'(rep_k_r) + atm_pkg::cnt_t'(1)) == rep_n;
  assign rep_beg  = beg_vld_r[rep_k_r] ? beg_pos_r[rep_k_r] : '0;
  assign rep_end  = end_vld_r[rep_k_r] ? end_pos_r[rep_k_r] : '0;
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    mode_end_nxt = mode_end_r;
    ptr_nxt      = ptr_r;
    pos_nxt      = pos_r;
    byte_nxt     = byte_r;
    rep_mode_nxt = rep_mode_r;
    rep_k_nxt    = rep_k_r;
    beg_vld_nxt  = beg_vld_r;
    end_vld_nxt  = end_vld_r;
    rec_we       = 1'b0;
    rec_open     = (e_kind == atm_pkg::KIND_OPEN);
    rec_idx      = atm_pkg::gidx_t'(e_opnd);
    out_load     = 1'b0;
    out_match_nxt = out_match_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (act)
            atm_pkg::ACT_LOAD: ;
            atm_pkg::ACT_START: begin
              ptr_nxt     = '0;
              pos_nxt     = '0;
              beg_vld_nxt = '0;
              end_vld_nxt = '0;
              phase_nxt   = atm_pkg::PH_RUN;
            end
            atm_pkg::ACT_BYTE: begin
              if (phase_r == atm_pkg::PH_RUN && ptr_r < used_len) begin
                byte_nxt     = in_byte;
                mode_end_nxt = 1'b0;
                state_nxt    = ST_SCAN;
              end else if (phase_r != atm_pkg::PH_IDLE) begin
                pos_nxt = pos_adv;
              end
            end
            atm_pkg::ACT_END: begin
              if (phase_r == atm_pkg::PH_RUN && ptr_r < used_len) begin
                mode_end_nxt = 1'b1;
                state_nxt    = ST_SCAN;
              end else if (phase_r != atm_pkg::PH_IDLE) begin
                phase_nxt    = atm_pkg::PH_IDLE;
                rep_k_nxt    = '0;
                state_nxt    = ST_REPORT;
                rep_mode_nxt = (phase_r == atm_pkg::PH_FAIL) ? REP_FAIL :
                               (rep_n == '0) ? REP_NONE : REP_GROUPS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (e_cap || (mode_end_r && e_kind == atm_pkg::KIND_END)) begin
          rec_we  = e_cap && (32'(e_opnd) < atm_pkg::MAX_GROUPS);
          if (rec_we && rec_open) begin
            beg_vld_nxt[rec_idx] = 1'b1;
          end
          if (rec_we && !rec_open) begin
            end_vld_nxt[rec_idx] = 1'b1;
          end
          ptr_nxt = ptr_inc;
          if (ptr_inc >= used_len) begin
            if (mode_end_r) begin
              phase_nxt    = atm_pkg::PH_IDLE;
              rep_k_nxt    = '0;
              rep_mode_nxt = (rep_n == '0) ? REP_NONE : REP_GROUPS;
              state_nxt    = ST_REPORT;
            end else begin
              pos_nxt   = pos_adv;
              state_nxt = ST_IDLE;
            end
          end
        end else if (!mode_end_r) begin
          if (byte_ok) begin
            ptr_nxt = ptr_inc;
          end else begin
            phase_nxt = atm_pkg::PH_FAIL;
          end
          pos_nxt   = pos_adv;
          state_nxt = ST_IDLE;
        end else begin
          phase_nxt    = atm_pkg::PH_IDLE;
          rep_k_nxt    = '0;
          rep_mode_nxt = REP_FAIL;
          state_nxt    = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (rep_mode_r)
            REP_FAIL: begin
              out_match_nxt = 1'b0;
              out_last_nxt  = 1'b1;
              out_data_nxt  = '0;
              state_nxt     = ST_IDLE;
            end
            REP_NONE: begin
              out_match_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              out_data_nxt  = '0;
              state_nxt     = ST_IDLE;
            end
            default: begin
              out_match_nxt = 1'b1;
              out_last_nxt  = rep_last;
              out_data_nxt  = {4'b0000,
                               beg_vld_r[rep_k_r] && end_vld_r[rep_k_r],
                               atm_pkg::out_pos_t'(rep_end),
                               atm_pkg::out_pos_t'(rep_beg),
                               atm_pkg::gnum_t'(rep_k_r)};
              rep_k_nxt     = rep_k_r + atm_pkg::gidx_t'(1);
              if (rep_last) begin
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_vld_nxt = out_load || (out_vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      cap_cnt_r <= '0;
      state_r   <= ST_IDLE;
      phase_r   <= atm_pkg::PH_IDLE;
      ptr_r     <= '0;
      pos_r     <= '0;
      beg_vld_r <= '0;
      end_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == atm_pkg::REG_PATTERN_LENGTH) begin
        pat_len_r <= cfg_data[atm_pkg::LEN_BITS-1:0];
      end
      if (cfg_we && cfg_index == atm_pkg::REG_CAPTURE_COUNT) begin
        cap_cnt_r <= cfg_data[atm_pkg::CNT_BITS-1:0];
      end
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      ptr_r     <= ptr_nxt;
      pos_r     <= pos_nxt;
      beg_vld_r <= beg_vld_nxt;
      end_vld_r <= end_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_end_r  <= mode_end_nxt;
    byte_r      <= byte_nxt;
    rep_mode_r  <= rep_mode_nxt;
    rep_k_r     <= rep_k_nxt;
    out_match_r <= out_match_nxt;
    out_last_r  <= out_last_nxt;
    out_data_r  <= out_data_nxt;
    if (rec_we && rec_open) begin
      beg_pos_r[rec_idx] <= pos_r;
    end
    if (rec_we && !rec_open) begin
      end_pos_r[rec_idx] <= pos_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_match_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: design/atm_checker.sv
// Port-level assertions for the anchored template matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "anchored_template_matcher_assert.svh"
module atm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  `ATM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `ATM_ASSERT_IMPL(a_fail_single, clk, rst_n, out_tvalid && !out_tuser, out_tlast && out_tdata == 40'd0)
  `ATM_ASSERT_IMPL(a_valid_needs_match, clk, rst_n, out_tvalid && out_tdata[35], out_tuser)
  `ATM_ASSERT_NEXT(a_run_continues, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tuser)

endmodule

bind anchored_template_matcher atm_checker u_atm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
